### src/meiu_pkg.sv
// Shared constants for the modular inverse unit: sequencer state codes and I/O width.
package meiu_pkg;

  localparam int unsigned STATE_W = 3;

  localparam logic [STATE_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [STATE_W-1:0] ST_CHECK = 3'd1;
  localparam logic [STATE_W-1:0] ST_ALIGN = 3'd2;
  localparam logic [STATE_W-1:0] ST_SUB   = 3'd3;
  localparam logic [STATE_W-1:0] ST_FIN   = 3'd4;

  localparam int unsigned IO_W = 32;

endpackage

### src/modular_inverse_ext_euclid_unit.sv
// Modular inverse by the extended Euclidean algorithm on one shared subtractor.
//
// One transfer in gives one result: value^-1 mod modulus in 0 .. modulus-1, or
// no_inverse with inverse 0 when gcd(value, modulus) != 1 or modulus is 0.
// Inputs are cut to their low WIDTH bits. Each Euclid step finds its quotient
// by shift-align and shift-subtract on a single WIDTH+2 bit subtractor, with
// the coefficient accumulated alongside. The number of Euclid steps is at
// most about 1.44*WIDTH + 2. in_ready is high only while the sequencer is
// idle, so it finishes one item before it takes the next; a finished result
// waits in the output register while the next item is taken in.
module modular_inverse_ext_euclid_unit #(
  parameter int unsigned WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_value,
  input  logic [31:0] in_modulus,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_inverse,
  output logic        out_no_inverse
);

  localparam int unsigned JW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int unsigned IOW = meiu_pkg::IO_W;

  logic [meiu_pkg::STATE_W-1:0] state_r, state_nxt;
  logic [WIDTH-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [WIDTH-1:0] ta_r, ta_nxt, tb_r, tb_nxt;
  logic [WIDTH-1:0] d_r, d_nxt, e_r, e_nxt;
  logic [WIDTH-1:0] m_r, m_nxt;
  logic [JW-1:0]    j_r, j_nxt;
  logic             par_r, par_nxt;
  logic [IOW-1:0]   out_inverse_r, out_inverse_nxt;
  logic             out_no_inverse_r, out_no_inverse_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [WIDTH+IOW-1:0] value_ext, modulus_ext, inv_ext;
  logic [WIDTH-1:0]     value_w, modulus_w;

  logic [WIDTH+1:0] opx, opy, diff;
  logic             ge;
  logic [WIDTH-1:0] a_sub, ta_sub, tm, inv_w;
  logic             ok, out_free;

  assign value_ext   = {{WIDTH{1'b0}}, in_value};
  assign modulus_ext = {{WIDTH{1'b0}}, in_modulus};
  assign value_w     = value_ext[WIDTH-1:0];
  assign modulus_w   = modulus_ext[WIDTH-1:0];

  assign tm = (ta_r == m_r) ? '0 : ta_r;

  // shared subtractor: align compare, subtract step, final normalization
  always_comb begin
    opx = {2'b00, a_r};
    opy = {2'b00, d_r};
    unique case (state_r)
      meiu_pkg::ST_ALIGN: opy = {1'b0, d_r, 1'b0};
      meiu_pkg::ST_FIN: begin
        opx = {2'b00, m_r};
        opy = {2'b00, tm};
      end
      default: ;
    endcase
  end

  assign diff = opx - opy;
  assign ge   = ~diff[WIDTH+1];

  assign a_sub  = ge ? diff[WIDTH-1:0] : a_r;
  assign ta_sub = ge ? (ta_r + e_r) : ta_r;

  assign ok    = (a_r == {{(WIDTH-1){1'b0}}, 1'b1}) && (m_r != '0);
  assign inv_w = par_r ? tm : ((tm == '0) ? '0 : diff[WIDTH-1:0]);
  assign inv_ext = {{IOW{1'b0}}, inv_w};

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt          = state_r;
    a_nxt              = a_r;
    b_nxt              = b_r;
    ta_nxt             = ta_r;
    tb_nxt             = tb_r;
    d_nxt              = d_r;
    e_nxt              = e_r;
    m_nxt              = m_r;
    j_nxt              = j_r;
    par_nxt            = par_r;
    out_inverse_nxt    = out_inverse_r;
    out_no_inverse_nxt = out_no_inverse_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    unique case (state_r)
      meiu_pkg::ST_IDLE: begin
        if (in_valid) begin
          // step from index -1 so the first quotient reduces value mod modulus
          a_nxt     = value_w;
          b_nxt     = modulus_w;
          m_nxt     = modulus_w;
          ta_nxt    = {{(WIDTH-1){1'b0}}, 1'b1};
          tb_nxt    = '0;
          par_nxt   = 1'b1;
          state_nxt = meiu_pkg::ST_CHECK;
        end
      end
      meiu_pkg::ST_CHECK: begin
        if (b_r == '0) begin
          state_nxt = meiu_pkg::ST_FIN;
        end else begin
          d_nxt     = b_r;
          e_nxt     = tb_r;
          j_nxt     = '0;
          state_nxt = meiu_pkg::ST_ALIGN;
        end
      end
      meiu_pkg::ST_ALIGN: begin
        if (ge) begin
          d_nxt = {d_r[WIDTH-2:0], 1'b0};
          e_nxt = {e_r[WIDTH-2:0], 1'b0};
          j_nxt = j_r + 1'b1;
        end else begin
          state_nxt = meiu_pkg::ST_SUB;
        end
      end
      meiu_pkg::ST_SUB: begin
        if (j_r == '0) begin
          a_nxt     = b_r;
          b_nxt     = a_sub;
          ta_nxt    = tb_r;
          tb_nxt    = ta_sub;
          par_nxt   = !par_r;
          state_nxt = meiu_pkg::ST_CHECK;
        end else begin
          a_nxt  = a_sub;
          ta_nxt = ta_sub;
          d_nxt  = {1'b0, d_r[WIDTH-1:1]};
          e_nxt  = {1'b0, e_r[WIDTH-1:1]};
          j_nxt  = j_r - 1'b1;
        end
      end
      meiu_pkg::ST_FIN: begin
        if (out_free) begin
          out_inverse_nxt    = ok ? inv_ext[IOW-1:0] : '0;
          out_no_inverse_nxt = !ok;
          out_valid_nxt      = 1'b1;
          state_nxt          = meiu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = meiu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= meiu_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r              <= a_nxt;
    b_r              <= b_nxt;
    ta_r             <= ta_nxt;
    tb_r             <= tb_nxt;
    d_r              <= d_nxt;
    e_r              <= e_nxt;
    m_r              <= m_nxt;
    j_r              <= j_nxt;
    par_r            <= par_nxt;
    out_inverse_r    <= out_inverse_nxt;
    out_no_inverse_r <= out_no_inverse_nxt;
  end

  assign in_ready       = (state_r == meiu_pkg::ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_inverse    = out_inverse_r;
  assign out_no_inverse = out_no_inverse_r;

  // divisor never zero while a quotient is being formed
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == meiu_pkg::ST_ALIGN || state_r == meiu_pkg::ST_SUB) |-> (d_r != '0))
    else $error("zero divisor in quotient step");

  // a transfer in starts the sequencer, which then holds off new input
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready after input transfer");

  // a flagged result always carries zero
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_inverse) |-> (out_inverse == '0))
    else $error("nonzero inverse with no_inverse");

  // subtract phase keeps the partial remainder below twice the shifted divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == meiu_pkg::ST_SUB) |-> ({1'b0, a_r} < {d_r, 1'b0}))
    else $error("partial remainder out of range");

  // new results are loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_inverse)))
    else $error("pending result overwritten");

endmodule
